### hw/rtl/sorted_key_value_table_defines.svh
// Assertion macros for the sorted key/value table checker.
// Every macro samples on clk; the first two are held off while rst is high.
`ifndef SORTED_KEY_VALUE_TABLE_DEFINES_SVH
`define SORTED_KEY_VALUE_TABLE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define SKVT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("skvt check failed");

// Next-cycle implication, held off during reset.
`define SKVT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("skvt check failed");

// Condition that must hold in the cycle after reset is seen.
`define SKVT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("skvt reset check failed");

`endif

### hw/rtl/skvt_pkg.sv
// Shared types and constants for the sorted key/value table.
// Used by the top level, the checker and the running-total unit.
`default_nettype none

package skvt_pkg;

  // Field widths fixed by the interface
  localparam int CMD_W     = 3;
  localparam int KEY_W     = 16;
  localparam int VALUE_W   = 20;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;
  localparam int TOTAL_W   = 24;

  // Default table depth
  localparam int ENTRIES_DEF = 16;

  // Saturation limits of the reported count and total
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_UPDATE = 3'd3,
    CMD_TOTAL  = 3'd4
  } cmd_t;

  // Status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // Operation request to the running-total unit
  typedef struct packed {
    logic add;  // total += operand
    logic sub;  // total -= operand
    logic inc;  // count += 1
    logic dec;  // count -= 1
  } acc_op_t;

endpackage

`default_nettype wire

### hw/rtl/skvt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependency; contents are undefined until written.
`default_nettype none

module skvt_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/skvt_acc.sv
// Running entry count and exact value total, with saturated views for output.
// Depends on skvt_pkg for widths, limits and the operation struct.
`default_nettype none

module skvt_acc #(
  parameter int ENTRIES = skvt_pkg::ENTRIES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire skvt_pkg::acc_op_t               op,
  input  wire logic [skvt_pkg::VALUE_W-1:0]    operand,
  output logic      [$clog2(ENTRIES+1)-1:0]    count,
  output logic      [skvt_pkg::COUNT_W-1:0]    count_sat,
  output logic      [skvt_pkg::TOTAL_W-1:0]    total_sat
);

  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int GROW_W = skvt_pkg::VALUE_W + CNT_W;
  localparam int SUM_W  = (GROW_W > skvt_pkg::TOTAL_W) ? GROW_W : skvt_pkg::TOTAL_W + 1;
  localparam int CMP_W  = (CNT_W > skvt_pkg::COUNT_W) ? CNT_W : skvt_pkg::COUNT_W;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic [SUM_W-1:0] operand_ext;
  logic [CNT_W-1:0] count_next;
  logic [CMP_W-1:0] count_ext;

  assign operand_ext = SUM_W'(operand);

  // Shared add/subtract on the exact total
  always_comb begin
    sum_next = sum;
    if (op.add) begin
      sum_next = sum + operand_ext;
    end else if (op.sub) begin
      sum_next = sum - operand_ext;
    end
  end

  always_comb begin
    count_next = count;
    if (op.inc) begin
      count_next = count + CNT_W'(1);
    end else if (op.dec) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else begin
      sum   <= sum_next;
      count <= count_next;
    end
  end

  // Clamp the reported figures
  assign count_ext = CMP_W'(count);
  assign count_sat = (count_ext > CMP_W'(skvt_pkg::COUNT_MAX)) ? skvt_pkg::COUNT_MAX
                                                               : count_ext[skvt_pkg::COUNT_W-1:0];
  assign total_sat = (sum > SUM_W'(skvt_pkg::TOTAL_MAX)) ? skvt_pkg::TOTAL_MAX
                                                        : sum[skvt_pkg::TOTAL_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/sorted_key_value_table.sv
// Sorted key/value table: one command at a time, input not ready until its result loads.
// Report total and unused codes go straight to the result; other commands binary-search the
// table (at most ceil(log2(ENTRIES+1)) probes), shift one entry per step on insert or delete,
// then, as the command needs, close the search step, decide, leave the shift, write, update
// the total and load the output; the next command is taken in the cycle after the result loads.
// One RAM port pair and a shared compare and adder do this; sync rst empties count and total.
`default_nettype none

module sorted_key_value_table #(
  parameter int ENTRIES = skvt_pkg::ENTRIES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [skvt_pkg::CMD_W-1:0]       command,
  input  wire logic [skvt_pkg::KEY_W-1:0]       key,
  input  wire logic [skvt_pkg::VALUE_W-1:0]     value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [skvt_pkg::STATUS_W-1:0]    status,
  output logic      [skvt_pkg::VALUE_W-1:0]     found_value,
  output logic      [skvt_pkg::COUNT_W-1:0]     entry_count,
  output logic      [skvt_pkg::TOTAL_W-1:0]     total_value
);

  localparam int AW    = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int KW    = skvt_pkg::KEY_W;
  localparam int VW    = skvt_pkg::VALUE_W;
  localparam int MEM_W = KW + VW;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SEARCH = 9'b000000010,
    S_CMP    = 9'b000000100,
    S_DECIDE = 9'b000001000,
    S_UP     = 9'b000010000,
    S_DOWN   = 9'b000100000,
    S_WRITE  = 9'b001000000,
    S_ADDV   = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t                          state;
  logic [skvt_pkg::CMD_W-1:0]      cmd_r;
  logic [KW-1:0]                   key_r;
  logic [VW-1:0]                   val_r;
  logic [CNT_W-1:0]                lo;
  logic [CNT_W-1:0]                hi;
  logic [AW-1:0]                   mid_r;
  logic [CNT_W-1:0]                pos;
  logic [CNT_W-1:0]                cur;
  logic                            pend;
  logic                            hit;
  logic [VW-1:0]                   found_r;
  logic [skvt_pkg::STATUS_W-1:0]   stat_r;

  logic [CNT_W:0]                  mid_sum;
  logic [AW-1:0]                   mid_w;
  logic [CNT_W-1:0]                cur_p1;
  logic [CNT_W-1:0]                cur_m1;
  logic [CNT_W-1:0]                cur_m2;
  logic [KW-1:0]                   rd_key;
  logic [VW-1:0]                   rd_val;
  logic                            in_beat;
  logic                            out_load;
  logic                            known_cmd;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [MEM_W-1:0]                ram_wdata;
  logic [AW-1:0]                   ram_raddr;
  logic [MEM_W-1:0]                ram_rdata;

  skvt_pkg::acc_op_t               acc_op;
  logic [VW-1:0]                   acc_operand;
  logic [CNT_W-1:0]                count;
  logic [skvt_pkg::COUNT_W-1:0]    count_sat;
  logic [skvt_pkg::TOTAL_W-1:0]    total_sat;

  // Entry storage: key in the upper bits, value in the lower bits
  skvt_ram #(
    .WIDTH (MEM_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Count and total
  skvt_acc #(
    .ENTRIES (ENTRIES)
  ) u_acc (
    .clk       (clk),
    .rst       (rst),
    .op        (acc_op),
    .operand   (acc_operand),
    .count     (count),
    .count_sat (count_sat),
    .total_sat (total_sat)
  );

  assign in_ready  = (state == S_IDLE);
  assign in_beat   = in_valid && in_ready;
  assign out_load  = (state == S_FINISH) && (!out_valid || out_ready);
  assign known_cmd = (command == skvt_pkg::CMD_INSERT) || (command == skvt_pkg::CMD_DELETE) ||
                     (command == skvt_pkg::CMD_LOOKUP) || (command == skvt_pkg::CMD_UPDATE);

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid_w   = mid_sum[AW:1];
  assign cur_p1  = cur + CNT_W'(1);
  assign cur_m1  = cur - CNT_W'(1);
  assign cur_m2  = cur - CNT_W'(2);
  assign rd_key  = ram_rdata[MEM_W-1:VW];
  assign rd_val  = ram_rdata[VW-1:0];

  // Pick the RAM read address and write request for the current step
  always_comb begin
    ram_raddr = mid_w;
    ram_we    = 1'b0;
    ram_waddr = pos[AW-1:0];
    ram_wdata = {key_r, val_r};
    case (state)
      S_UP: begin
        ram_raddr = cur_m1[AW-1:0];
        ram_we    = pend;
        ram_waddr = cur_p1[AW-1:0];
        ram_wdata = ram_rdata;
      end
      S_DOWN: begin
        ram_raddr = cur[AW-1:0];
        ram_we    = pend;
        ram_waddr = cur_m2[AW-1:0];
        ram_wdata = ram_rdata;
      end
      S_WRITE: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Drive the count and total unit
  always_comb begin
    acc_op      = '0;
    acc_operand = found_r;
    case (state)
      S_WRITE: begin
        if (cmd_r == skvt_pkg::CMD_INSERT) begin
          acc_op.inc = 1'b1;
        end else begin
          acc_op.sub = 1'b1;
        end
      end
      S_ADDV: begin
        acc_op.add  = 1'b1;
        acc_operand = val_r;
      end
      S_DOWN: begin
        if (!(cur < count)) begin
          acc_op.sub = 1'b1;
          acc_op.dec = 1'b1;
        end
      end
      default: begin
        acc_op = '0;
      end
    endcase
  end

  // Sequencer: search, decide, shift, write, report
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            state <= known_cmd ? S_SEARCH : S_FINISH;
          end
        end
        S_SEARCH: begin
          state <= (lo == hi) ? S_DECIDE : S_CMP;
        end
        S_CMP: begin
          state <= (rd_key == key_r) ? S_DECIDE : S_SEARCH;
        end
        S_DECIDE: begin
          state <= S_FINISH;
          if (cmd_r == skvt_pkg::CMD_INSERT) begin
            if (!hit && count != CNT_W'(ENTRIES)) begin
              state <= S_UP;
            end
          end else if (cmd_r == skvt_pkg::CMD_DELETE) begin
            if (hit) begin
              state <= S_DOWN;
            end
          end else if (cmd_r == skvt_pkg::CMD_UPDATE) begin
            if (hit) begin
              state <= S_WRITE;
            end
          end
        end
        S_UP: begin
          if (!(cur > pos)) begin
            state <= S_WRITE;
          end
        end
        S_DOWN: begin
          if (!(cur < count)) begin
            state <= S_FINISH;
          end
        end
        S_WRITE: begin
          state <= S_ADDV;
        end
        S_ADDV: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Working registers of the current command
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_beat) begin
          cmd_r   <= command;
          key_r   <= key;
          val_r   <= value;
          lo      <= '0;
          hi      <= count;
          hit     <= 1'b0;
          found_r <= '0;
          stat_r  <= skvt_pkg::ST_OK;
        end
      end
      S_SEARCH: begin
        mid_r <= mid_w;
        pos   <= lo;
      end
      S_CMP: begin
        if (rd_key == key_r) begin
          hit     <= 1'b1;
          pos     <= CNT_W'(mid_r);
          found_r <= rd_val;
        end else if (rd_key < key_r) begin
          lo <= CNT_W'(mid_r) + CNT_W'(1);
        end else begin
          hi <= CNT_W'(mid_r);
        end
      end
      S_DECIDE: begin
        pend <= 1'b0;
        if (cmd_r == skvt_pkg::CMD_INSERT) begin
          cur <= count;
          if (hit) begin
            stat_r <= skvt_pkg::ST_DUP;
          end else if (count == CNT_W'(ENTRIES)) begin
            stat_r <= skvt_pkg::ST_FULL;
          end
        end else begin
          cur <= pos + CNT_W'(1);
          if (!hit && cmd_r != skvt_pkg::CMD_TOTAL) begin
            stat_r <= skvt_pkg::ST_MISSING;
          end
        end
      end
      S_UP: begin
        // Move entry cur-1 up by one; its write lands next cycle
        if (cur > pos) begin
          cur  <= cur_m1;
          pend <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end
      S_DOWN: begin
        // Move entry cur down by one; its write lands next cycle
        if (cur < count) begin
          cur  <= cur_p1;
          pend <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end
      default: begin
        pend <= pend;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= stat_r;
      found_value <= (cmd_r == skvt_pkg::CMD_LOOKUP && hit) ? found_r : '0;
      entry_count <= count_sat;
      total_value <= total_sat;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/skvt_checker.sv
// Port-level checks for the sorted key/value table, attached by bind.
// Depends on skvt_pkg and the assertion macros in the defines header.
`default_nettype none
`include "sorted_key_value_table_defines.svh"

module skvt_checker #(
  parameter int ENTRIES = skvt_pkg::ENTRIES_DEF
) (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [skvt_pkg::STATUS_W-1:0]  status,
  input wire logic [skvt_pkg::VALUE_W-1:0]   found_value,
  input wire logic [skvt_pkg::COUNT_W-1:0]   entry_count,
  input wire logic [skvt_pkg::TOTAL_W-1:0]   total_value
);

  // A stalled result beat holds its status and total
  `SKVT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(total_value))
  // A nonzero looked-up value only comes with an ok status
  `SKVT_IMPLIES(a_found_ok, out_valid && found_value != '0, status == skvt_pkg::ST_OK)
  // Count never exceeds the table depth
  `SKVT_IMPLIES(a_count_range, out_valid, int'(entry_count) <= ENTRIES)
  // The block is busy in the cycle after it takes a command
  `SKVT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  // No result beat right after reset
  `SKVT_AFTER_RESET(a_reset_quiet, !out_valid)

endmodule

bind sorted_key_value_table skvt_checker #(
  .ENTRIES (ENTRIES)
) u_skvt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .found_value (found_value),
  .entry_count (entry_count),
  .total_value (total_value)
);

`default_nettype wire
